// ----- src/assert_macros.svh -----
// Assertion macros for the box transform block.
// Included by RTL files that carry concurrent checks; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- src/bta_pkg.sv -----
// Package for the box transform block: payload types, states and limits.
// No dependencies.
package bta_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned SumW  = 36;

  typedef struct packed {
    logic [1:0]        row_index;
    logic signed [31:0] entry_a;
    logic signed [31:0] entry_b;
    logic signed [31:0] entry_c;
    logic signed [31:0] entry_d;
  } row_t;

  typedef struct packed {
    logic signed [31:0] low_x;
    logic signed [31:0] low_y;
    logic signed [31:0] low_z;
    logic signed [31:0] high_x;
    logic signed [31:0] high_y;
    logic signed [31:0] high_z;
    logic               w_fault;
  } box_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM, ST_DIV_START, ST_DIV_WAIT, ST_NEXT, ST_OUT
  } state_e;

  localparam logic [1:0] LastRow = 2'd3;
endpackage

// ----- src/bta_if.sv -----
// Valid/ready channel interfaces for the box transform block.
// Depends on bta_pkg.
interface bta_row_if;
  import bta_pkg::*;
  logic valid;
  logic ready;
  row_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bta_box_if;
  import bta_pkg::*;
  logic valid;
  logic ready;
  box_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/box_transform_aabb.sv -----
// Box transform AABB: takes a 4x4 Q-format matrix as four row transfers (row 0..3).
// Rows 0..2 are stored. Row 3 starts a sequencer that, for each of 8 corners,
// forms 4 sums in a shared adder, then runs 3 divides through one bit-serial
// divider, then steps to the next corner. No rows are accepted while the
// sequencer runs. The box waits in an output register until taken, so rows
// are accepted meanwhile; the sequencer holds in its last state only while
// the previous box is still untaken. w_fault flags zero w or saturation.
module box_transform_aabb #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic clk_i,
  input logic rst_ni,
  bta_row_if.sink   row_i,
  bta_box_if.source box_o
);
  import bta_pkg::*;
`include "assert_macros.svh"

  logic signed [DataW-1:0] mat_q [12];
  logic signed [DataW-1:0] r3_q [4];
  logic signed [SumW-1:0]  v_q [4];
  state_e     state_q, state_d;
  logic [2:0] corner_q, corner_d;
  logic [1:0] col_q, col_d;
  logic [1:0] axis_q, axis_d;
  logic       fault_q, fault_d;
  logic signed [DataW-1:0] lo_q [3];
  logic signed [DataW-1:0] hi_q [3];
  logic       out_valid_q;
  box_t       box_q;
  logic       out_load;
  logic       div_start, div_done, div_fault;
  logic signed [DataW-1:0] quo;
  logic signed [SumW-1:0]  sum;
  logic       row_acc;

  assign row_i.ready = (state_q == ST_IDLE);
  assign row_acc = row_i.valid && row_i.ready;
  // finished box moves to the output register once the previous one is gone
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || box_o.ready);

  // one column sum per cycle: +-m0 +-m1 +-m2 + 2*m3
  always_comb begin
    logic signed [SumW-1:0] t0, t1, t2;
    t0 = SumW'(mat_q[{2'd0, col_q}]);
    t1 = SumW'(mat_q[4'd4 + {2'd0, col_q}]);
    t2 = SumW'(mat_q[4'd8 + {2'd0, col_q}]);
    sum = (corner_q[0] ? t0 : -t0) + (corner_q[1] ? t1 : -t1)
        + (corner_q[2] ? t2 : -t2) + (SumW'(r3_q[col_q]) <<< 1);
  end

  bta_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(v_q[axis_q]), .den_i(v_q[3]),
    .done_o(div_done), .quo_o(quo), .fault_o(div_fault)
  );

  always_comb begin
    state_d = state_q; corner_d = corner_q; col_d = col_q; axis_d = axis_q;
    fault_d = fault_q; div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (row_acc && row_i.data.row_index == LastRow) begin
          state_d = ST_SUM; corner_d = '0; col_d = '0; fault_d = 1'b0;
        end
      end
      ST_SUM: begin
        col_d = col_q + 2'd1;
        if (col_q == 2'd3) begin
          state_d = ST_DIV_START; axis_d = '0;
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1; state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          fault_d = fault_q | div_fault;
          if (axis_q == 2'd2) state_d = ST_NEXT;
          else begin
            axis_d = axis_q + 2'd1; state_d = ST_DIV_START;
          end
        end
      end
      ST_NEXT: begin
        corner_d = corner_q + 3'd1;
        state_d = (corner_q == 3'd7) ? ST_OUT : ST_SUM;
      end
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; corner_q <= '0; col_q <= '0; axis_q <= '0;
      fault_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; corner_q <= corner_d; col_q <= col_d;
      axis_q <= axis_d; fault_q <= fault_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (box_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_acc) begin
      if (row_i.data.row_index == LastRow) begin
        r3_q[0] <= row_i.data.entry_a; r3_q[1] <= row_i.data.entry_b;
        r3_q[2] <= row_i.data.entry_c; r3_q[3] <= row_i.data.entry_d;
      end else begin
        mat_q[{row_i.data.row_index, 2'd0}] <= row_i.data.entry_a;
        mat_q[{row_i.data.row_index, 2'd1}] <= row_i.data.entry_b;
        mat_q[{row_i.data.row_index, 2'd2}] <= row_i.data.entry_c;
        mat_q[{row_i.data.row_index, 2'd3}] <= row_i.data.entry_d;
      end
    end
    if (state_q == ST_SUM) v_q[col_q] <= sum;
    if (state_q == ST_DIV_WAIT && div_done) begin
      if (corner_q == 3'd0 || quo < lo_q[axis_q]) lo_q[axis_q] <= quo;
      if (corner_q == 3'd0 || quo > hi_q[axis_q]) hi_q[axis_q] <= quo;
    end
    if (out_load) begin
      box_q <= '{low_x: lo_q[0], low_y: lo_q[1], low_z: lo_q[2],
                 high_x: hi_q[0], high_y: hi_q[1], high_z: hi_q[2],
                 w_fault: fault_q};
    end
  end

  assign box_o.valid = out_valid_q;
  assign box_o.data = box_q;

  `ASSERT_IMPLIES(a_no_accept_busy, clk_i, rst_ni, state_q != ST_IDLE, !row_i.ready)
  `ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_q && !box_o.ready, out_valid_q)
  `ASSERT_NEXT(a_out_after_seq, clk_i, rst_ni, out_load, out_valid_q)
endmodule

// ----- src/bta_div.sv -----
// Bit-serial signed fixed-point divider with saturation for the box block.
// Depends on bta_pkg.
module bta_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic signed [bta_pkg::SumW-1:0] num_i,
  input  logic signed [bta_pkg::SumW-1:0] den_i,
  output logic done_o,
  output logic signed [bta_pkg::DataW-1:0] quo_o,
  output logic fault_o
);
  import bta_pkg::*;
  localparam int unsigned DivW = SumW + FRAC_BITS;
  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0]  dvd_q, dvd_d;
  logic [SumW:0]    rem_q, rem_d;
  logic [SumW-1:0]  dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, neg_q, neg_d, zero_q, zero_d, nsgn_q, nsgn_d;
  logic             done_q, done_d;
  logic [SumW:0]    trial;
  logic [DivW-1:0]  q_abs;
  logic [SumW-1:0]  un, uw;

  assign un = num_i[SumW-1] ? SumW'(-num_i) : SumW'(num_i);
  assign uw = den_i[SumW-1] ? SumW'(-den_i) : SumW'(den_i);
  assign trial = {rem_q[SumW-1:0], dvd_q[DivW-1]} - {1'b0, dvs_q};

  always_comb begin
    dvd_d = dvd_q; rem_d = rem_q; dvs_d = dvs_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q; zero_d = zero_q; nsgn_d = nsgn_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = {un, {FRAC_BITS{1'b0}}};
      rem_d  = '0;
      dvs_d  = uw;
      cnt_d  = CntW'(DivW);
      busy_d = 1'b1;
      neg_d  = num_i[SumW-1] ^ den_i[SumW-1];
      zero_d = (den_i == '0);
      nsgn_d = num_i[SumW-1] ? 1'b0 : (num_i != '0);
    end else if (busy_q) begin
      if (!trial[SumW]) begin
        rem_d = trial;
        dvd_d = {dvd_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[SumW-1:0], dvd_q[DivW-1]};
        dvd_d = {dvd_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d; rem_q <= rem_d; dvs_q <= dvs_d;
    neg_q <= neg_d; zero_q <= zero_d; nsgn_q <= nsgn_d;
  end

  // dvd_q holds the quotient once done
  assign q_abs = dvd_q;
  assign done_o = done_q;

  always_comb begin
    fault_o = 1'b0;
    if (zero_q) begin
      // numerator sign was captured; zero numerator gives zero, neg gives min
      fault_o = 1'b1;
      if (nsgn_q) quo_o = {1'b0, {(DataW-1){1'b1}}};
      else if (neg_q) quo_o = {1'b1, {(DataW-1){1'b0}}};
      else quo_o = '0;
    end else if (neg_q) begin
      if (q_abs > DivW'({1'b1, {(DataW-1){1'b0}}})) begin
        fault_o = 1'b1;
        quo_o = {1'b1, {(DataW-1){1'b0}}};
      end else begin
        quo_o = DataW'(-q_abs);
      end
    end else if (q_abs > DivW'({1'b0, {(DataW-1){1'b1}}})) begin
      fault_o = 1'b1;
      quo_o = {1'b0, {(DataW-1){1'b1}}};
    end else begin
      quo_o = q_abs[DataW-1:0];
    end
  end
endmodule
